[hw/rtl/j5u_pkg.sv]
// Shared types, character codes and helper functions for the JSON5 string unescaper.
// Has no dependencies. Every other file imports it.
package j5u_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int CP_KEEP_W   = 12;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_req;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [2:0] error_code;
    } out_item_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_BODY     = 3'd1,
        MODE_ESC      = 3'd2,
        MODE_HEX      = 3'd3,
        MODE_AFTER_CR = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_NEWLINE = 3'd1,
        ERR_ESCAPE  = 3'd2,
        ERR_HEX     = 3'd3,
        ERR_EOI     = 3'd4
    } err_t;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTL_BS    = 8'h08;
    localparam logic [7:0] CTL_FF    = 8'h0C;
    localparam logic [7:0] CTL_TAB   = 8'h09;

    // Return {is_hex, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic out_item_t byte_item(input logic [7:0] b);
        out_item_t r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.last       = 1'b0;
        r.error_code = ERR_NONE;
        return r;
    endfunction

    function automatic out_item_t end_item(input err_t e);
        out_item_t r;
        r.out_byte   = '0;
        r.byte_valid = 1'b0;
        r.last       = 1'b1;
        r.error_code = e;
        return r;
    endfunction

endpackage

[hw/rtl/json5_string_unescape.sv]
// Top level of the JSON5 string unescaper: input register, decoder, result queue.
// Depends on j5u_pkg, j5u_decode and j5u_out_queue.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-----------------------------------------
//  input   | in_valid / in_stall     | in_data  : in_item_t  (byte, start, end)
//  output  | out_valid / out_stall   | out_data : out_item_t (byte, flags, code)
//
// One item is taken per cycle while in_stall is low. An accepted item is held
// in the input register, then its results wait in the result queue. A \u escape
// that encodes to two or three bytes pushes them all at once; they leave by the
// single output port in turn, and the four-entry queue sets how soon input stalls.
// Reset clears the scanner state and empties the queue; no clearing pass.
// Stalls on the output back up into the queue and then onto in_stall.
module json5_string_unescape
    import j5u_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    // Input register: holds the item being decoded this cycle.
    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;

    logic              in_accept;
    logic              advance;
    logic              pop;
    logic [PCNT_W-1:0] push_cnt;
    out_item_t         push_items [MAX_RESULTS];
    logic [QCNT_W-1:0] space;

    // Advance the held item once all of its results fit in the queue.
    assign advance   = in_valid_reg && (space >= QCNT_W'(push_cnt));
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    assign in_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload: load on accept, otherwise hold.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_data;
        end
    end

    j5u_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (in_item_reg),
        .advance    (advance),
        .push_cnt   (push_cnt),
        .push_items (push_items)
    );

    j5u_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (advance),
        .push_cnt   (push_cnt),
        .push_items (push_items),
        .pop        (pop),
        .head_valid (out_valid),
        .head       (out_data),
        .space      (space)
    );

endmodule

[hw/rtl/j5u_decode.sv]
// Scanner state and combinational decode of one registered input item.
// Depends on j5u_pkg.
module j5u_decode
    import j5u_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  logic      advance,
    output logic [PCNT_W-1:0] push_cnt,
    output out_item_t push_items [MAX_RESULTS]
);

    mode_t                mode_reg, mode_next;
    logic                 sq_reg, sq_next;
    logic [1:0]           hex_cnt_reg, hex_cnt_next;
    logic [CP_KEEP_W-1:0] cp_reg, cp_next;

    logic        active;
    logic        do_body;
    logic [7:0]  c;
    logic [7:0]  quote;
    logic [4:0]  hx;
    logic [15:0] full_cp;

    assign c       = item.in_byte;
    assign quote   = sq_reg ? CH_SQUOTE : CH_DQUOTE;
    assign hx      = hex_digit(c);
    assign full_cp = {cp_reg, hx[3:0]};
    assign active  = (mode_reg == MODE_BODY) || (mode_reg == MODE_ESC) ||
                     (mode_reg == MODE_HEX) || (mode_reg == MODE_AFTER_CR);

    always_comb
    begin
        mode_next    = mode_reg;
        sq_next      = sq_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        push_cnt     = '0;
        do_body      = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            push_items[i] = '0;
        end

        if (item.end_of_input)
        begin
            mode_next = MODE_IDLE;
            if (active)
            begin
                hex_cnt_next  = '0;
                cp_next       = '0;
                push_cnt      = PCNT_W'(1);
                push_items[0] = end_item(ERR_EOI);
            end
        end
        else if (item.start_req)
        begin
            mode_next    = MODE_BODY;
            sq_next      = (c == CH_SQUOTE);
            hex_cnt_next = '0;
            cp_next      = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_BODY:
                begin
                    do_body = 1'b1;
                end
                MODE_AFTER_CR:
                begin
                    if (c == CH_LF)
                    begin
                        mode_next     = MODE_BODY;
                        push_cnt      = PCNT_W'(1);
                        push_items[0] = byte_item(c);
                    end
                    else
                    begin
                        do_body = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_BODY;
                    push_cnt  = PCNT_W'(1);
                    unique case (c)
                        CH_DQUOTE, CH_SLASH, CH_SQUOTE, CH_BSLASH, CH_LF:
                            push_items[0] = byte_item(c);
                        CH_CR:
                        begin
                            mode_next     = MODE_AFTER_CR;
                            push_items[0] = byte_item(c);
                        end
                        CH_B: push_items[0] = byte_item(CTL_BS);
                        CH_F: push_items[0] = byte_item(CTL_FF);
                        CH_N: push_items[0] = byte_item(CH_LF);
                        CH_R: push_items[0] = byte_item(CH_CR);
                        CH_T: push_items[0] = byte_item(CTL_TAB);
                        CH_U:
                        begin
                            mode_next    = MODE_HEX;
                            hex_cnt_next = '0;
                            cp_next      = '0;
                            push_cnt     = '0;
                        end
                        default:
                        begin
                            mode_next     = MODE_IDLE;
                            hex_cnt_next  = '0;
                            cp_next       = '0;
                            push_items[0] = end_item(ERR_ESCAPE);
                        end
                    endcase
                end
                MODE_HEX:
                begin
                    if (!hx[4])
                    begin
                        mode_next     = MODE_IDLE;
                        hex_cnt_next  = '0;
                        cp_next       = '0;
                        push_cnt      = PCNT_W'(1);
                        push_items[0] = end_item(ERR_HEX);
                    end
                    else if (hex_cnt_reg != 2'd3)
                    begin
                        cp_next      = {cp_reg[CP_KEEP_W-5:0], hx[3:0]};
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        // Fourth digit: encode the code point as UTF-8.
                        mode_next    = MODE_BODY;
                        hex_cnt_next = '0;
                        cp_next      = '0;
                        if (full_cp[15:7] == '0)
                        begin
                            push_cnt      = PCNT_W'(1);
                            push_items[0] = byte_item({1'b0, full_cp[6:0]});
                        end
                        else if (full_cp[15:11] == '0)
                        begin
                            push_cnt      = PCNT_W'(2);
                            push_items[0] = byte_item({3'b110, full_cp[10:6]});
                            push_items[1] = byte_item({2'b10, full_cp[5:0]});
                        end
                        else
                        begin
                            push_cnt      = PCNT_W'(3);
                            push_items[0] = byte_item({4'b1110, full_cp[15:12]});
                            push_items[1] = byte_item({2'b10, full_cp[11:6]});
                            push_items[2] = byte_item({2'b10, full_cp[5:0]});
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            if (do_body)
            begin
                mode_next = MODE_BODY;
                if (c == quote)
                begin
                    mode_next     = MODE_IDLE;
                    hex_cnt_next  = '0;
                    cp_next       = '0;
                    push_cnt      = PCNT_W'(1);
                    push_items[0] = end_item(ERR_NONE);
                end
                else if (c == CH_LF || c == CH_CR)
                begin
                    mode_next     = MODE_IDLE;
                    hex_cnt_next  = '0;
                    cp_next       = '0;
                    push_cnt      = PCNT_W'(1);
                    push_items[0] = end_item(ERR_NEWLINE);
                end
                else if (c == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    push_cnt      = PCNT_W'(1);
                    push_items[0] = byte_item(c);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            sq_reg      <= 1'b0;
            hex_cnt_reg <= '0;
            cp_reg      <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            sq_reg      <= sq_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

[hw/rtl/j5u_out_queue.sv]
// Short shifting result queue: takes up to three items a cycle, hands out one.
// Depends on j5u_pkg.
module j5u_out_queue
    import j5u_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [PCNT_W-1:0] push_cnt,
    input  out_item_t         push_items [MAX_RESULTS],
    input  logic              pop,
    output logic              head_valid,
    output out_item_t         head,
    output logic [QCNT_W-1:0] space
);

    out_item_t         q_reg  [QUEUE_DEPTH];
    out_item_t         q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QCNT_W-1:0] base;
    logic [QCNT_W-1:0] n_in;
    logic [QCNT_W-1:0] rel [QUEUE_DEPTH];

    assign base       = count_reg - QCNT_W'(pop);
    assign n_in       = push ? QCNT_W'(push_cnt) : '0;
    assign space      = QCNT_W'(QUEUE_DEPTH) - base;
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[0];
    assign count_next = base + n_in;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            rel[i] = QCNT_W'(i) - base;
            if (QCNT_W'(i) >= base && rel[i] < n_in)
            begin
                q_next[i] = push_items[rel[i][PCNT_W-1:0]];
            end
            else if (pop)
            begin
                q_next[i] = q_reg[(i + 1) % QUEUE_DEPTH];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/j5u_checker.sv]
// Port-level checks for the JSON5 string unescaper, bound to the top level.
// Depends on j5u_pkg and json5_string_unescape.
module j5u_checker
    import j5u_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled item changed or dropped");

    // Only the item that ends a string carries no byte.
    a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.last)
        else $error("result without byte that does not end the string");

    // An error always ends the string and carries no byte.
    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != ERR_NONE
            |-> out_data.last && !out_data.byte_valid)
        else $error("error result not a string end");

    // Error code stays within the defined set.
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.error_code == ERR_NONE ||
                      out_data.error_code == ERR_NEWLINE ||
                      out_data.error_code == ERR_ESCAPE ||
                      out_data.error_code == ERR_HEX ||
                      out_data.error_code == ERR_EOI)
        else $error("undefined error code");

    // Nothing comes out and input is not held off right after reset is released.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("result present or input stalled straight after reset");

endmodule

bind json5_string_unescape j5u_checker u_checker (.*);

[test/json5_string_unescape_test.sv]
// Self-checking testbench for json5_string_unescape: directed and random JSON5 strings.
// Depends on j5u_pkg and the json5_string_unescape RTL; needs no other file.
module json5_string_unescape_test;
    import j5u_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_F = 8'h46;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_F = 8'h66;

    // Escapes that map to a single byte and leave the body mode as it was.
    localparam logic [7:0] SIMPLE_ESC [10] = '{CH_DQUOTE, CH_SLASH, CH_SQUOTE, CH_BSLASH, CH_LF,
                                               CH_B, CH_F, CH_N, CH_R, CH_T};

    // Tracks the decoder state, works out the bytes each accepted item yields
    // and compares the results in order.
    class unescape_scoreboard;
        out_item_t expected_out[$];
        mode_t     scan_mode;
        bit        quote_single;
        bit [1:0]  digits_seen;
        bit [15:0] code_acc;
        int        errors;
        int        items_in;
        int        results_out;
        int        closed_ok;
        int        closed_err;

        function new();
            scan_mode    = MODE_IDLE;
            quote_single = 1'b0;
            digits_seen  = '0;
            code_acc     = '0;
            errors       = 0;
            items_in     = 0;
            results_out  = 0;
            closed_ok    = 0;
            closed_err   = 0;
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        function int nibble_of(logic [7:0] c);
            if (c >= DIGIT_0 && c <= DIGIT_9)
                return int'(c - DIGIT_0);
            if (c >= LOWER_A && c <= LOWER_F)
                return int'(c - LOWER_A) + 10;
            if (c >= UPPER_A && c <= UPPER_F)
                return int'(c - UPPER_A) + 10;
            return -1;
        endfunction

        function void emit_byte(logic [7:0] b);
            out_item_t r;
            r.out_byte   = b;
            r.byte_valid = 1'b1;
            r.last       = 1'b0;
            r.error_code = ERR_NONE;
            expected_out = {expected_out, r};
        endfunction

        function void end_string(err_t e);
            out_item_t r;
            r.out_byte   = '0;
            r.byte_valid = 1'b0;
            r.last       = 1'b1;
            r.error_code = e;
            expected_out = {expected_out, r};
            scan_mode   = MODE_IDLE;
            digits_seen = '0;
            code_acc    = '0;
            if (e == ERR_NONE)
                closed_ok++;
            else
                closed_err++;
        endfunction

        function void body_char(logic [7:0] c);
            scan_mode = MODE_BODY;
            if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE))
                end_string(ERR_NONE);
            else if (c == CH_LF || c == CH_CR)
                end_string(ERR_NEWLINE);
            else if (c == CH_BSLASH)
                scan_mode = MODE_ESC;
            else
                emit_byte(c);
        endfunction

        function void decode_input(in_item_t it);
            logic [7:0]  c;
            logic [15:0] cp;
            int          nib;
            c = it.in_byte;
            items_in++;
            // End of input wins over start.
            if (it.end_of_input)
            begin
                if (scan_mode >= MODE_BODY && scan_mode <= MODE_AFTER_CR)
                    end_string(ERR_EOI);
                else
                    scan_mode = MODE_IDLE;
                return;
            end
            // A start drops any open string silently.
            if (it.start_req)
            begin
                scan_mode    = MODE_BODY;
                quote_single = (c == CH_SQUOTE);
                digits_seen  = '0;
                code_acc     = '0;
                return;
            end
            case (scan_mode)
                MODE_BODY:
                    body_char(c);
                MODE_AFTER_CR:
                begin
                    if (c == CH_LF)
                    begin
                        scan_mode = MODE_BODY;
                        emit_byte(c);
                    end
                    else
                        body_char(c);
                end
                MODE_ESC:
                begin
                    scan_mode = MODE_BODY;
                    case (c)
                        CH_DQUOTE, CH_SLASH, CH_SQUOTE, CH_BSLASH, CH_LF:
                            emit_byte(c);
                        CH_CR:
                        begin
                            scan_mode = MODE_AFTER_CR;
                            emit_byte(c);
                        end
                        CH_B: emit_byte(CTL_BS);
                        CH_F: emit_byte(CTL_FF);
                        CH_N: emit_byte(CH_LF);
                        CH_R: emit_byte(CH_CR);
                        CH_T: emit_byte(CTL_TAB);
                        CH_U:
                        begin
                            scan_mode   = MODE_HEX;
                            digits_seen = '0;
                            code_acc    = '0;
                        end
                        default:
                            end_string(ERR_ESCAPE);
                    endcase
                end
                MODE_HEX:
                begin
                    nib = nibble_of(c);
                    if (nib < 0)
                        end_string(ERR_HEX);
                    else
                    begin
                        cp = {code_acc[11:0], 4'(nib)};
                        if (digits_seen != 2'd3)
                        begin
                            code_acc = cp;
                            digits_seen++;
                        end
                        else
                        begin
                            scan_mode   = MODE_BODY;
                            digits_seen = '0;
                            code_acc    = '0;
                            if (cp < 16'h0080)
                                emit_byte(cp[7:0]);
                            else if (cp < 16'h0800)
                            begin
                                emit_byte({3'b110, cp[10:6]});
                                emit_byte({2'b10, cp[5:0]});
                            end
                            else
                            begin
                                emit_byte({4'b1110, cp[15:12]});
                                emit_byte({2'b10, cp[11:6]});
                                emit_byte({2'b10, cp[5:0]});
                            end
                        end
                    end
                end
                default:
                    scan_mode = MODE_IDLE;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results_out++;
            if (expected_out.size() == 0)
            begin
                $error("result with nothing expected: byte %h valid %b last %b code %0d",
                       got.out_byte, got.byte_valid, got.last, got.error_code);
                errors++;
                return;
            end
            want = expected_out.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.byte_valid !== want.byte_valid)
            begin
                $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, got.last);
                errors++;
            end
            if (got.error_code !== want.error_code)
            begin
                $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    unescape_scoreboard sb;
    in_item_t           stim_q[$];
    bit                 in_taken       = 1'b0;
    bit                 hold_req       = 1'b0;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;

    json5_string_unescape uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sample both channels at the rising edge; in_taken tells the sender,
    // at the following falling edge, whether its item went in.
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
            sb.decode_input(in_data);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Receiver: random stall, or a long hold-off on request so that the
    // result queue fills and the block stalls its input.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("json5_string_unescape_test: errors");
        $finish;
    end

    function automatic void add_item(logic [7:0] b, logic start, logic eoi);
        in_item_t it;
        it.in_byte      = b;
        it.start_req    = start;
        it.end_of_input = eoi;
        stim_q = {stim_q, it};
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return DIGIT_0 + 8'(n);
        return ($urandom_range(1) ? UPPER_A : LOWER_A) + 8'(n) - 8'd10;
    endfunction

    function automatic void add_hex_escape(logic [15:0] cp);
        add_item(CH_BSLASH, 1'b0, 1'b0);
        add_item(CH_U, 1'b0, 1'b0);
        add_item(hex_char(cp[15:12]), 1'b0, 1'b0);
        add_item(hex_char(cp[11:8]), 1'b0, 1'b0);
        add_item(hex_char(cp[7:4]), 1'b0, 1'b0);
        add_item(hex_char(cp[3:0]), 1'b0, 1'b0);
    endfunction

    // Offer every queued item in turn, idling at random before each one,
    // and hold it until it is taken. Called and left at a falling edge.
    task automatic send_all();
        in_item_t it;
        while (stim_q.size() != 0)
        begin
            it = stim_q.pop_front();
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= it;
            @(negedge clk);
            while (!in_taken)
                @(negedge clk);
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Build random strings until about n items that the block acts on are
    // queued, then send them. Most strings are well formed; the rest end
    // in one of the error cases or are cut short by a fresh start.
    task automatic run_phase(int idle_pct, int stall_pct, int n);
        int          real_items;
        int          start_size;
        int          r;
        int          k;
        int          body_len;
        logic [7:0]  q;
        logic [7:0]  close;
        logic [7:0]  b;
        logic [15:0] cp;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        real_items     = 0;
        while (real_items < n)
        begin
            start_size = stim_q.size();
            r = $urandom_range(99);
            if (r < 45)
                q = CH_DQUOTE;
            else if (r < 90)
                q = CH_SQUOTE;
            else
                q = 8'($urandom_range(255));
            close = (q == CH_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
            add_item(q, 1'b1, 1'b0);
            body_len = $urandom_range(8);
            for (int i = 0; i < body_len; i++)
            begin
                r = $urandom_range(9);
                if (r < 5)
                begin
                    b = 8'($urandom_range(255));
                    if (b == close || b == CH_BSLASH || b == CH_LF || b == CH_CR)
                        b = LOWER_A;
                    add_item(b, 1'b0, 1'b0);
                end
                else if (r < 7)
                begin
                    add_item(CH_BSLASH, 1'b0, 1'b0);
                    add_item(SIMPLE_ESC[$urandom_range(9)], 1'b0, 1'b0);
                end
                else if (r == 7)
                begin
                    k = $urandom_range(3);
                    if (k == 0)
                        cp = 16'($urandom_range(16'h007F));
                    else if (k == 1)
                        cp = 16'($urandom_range(16'h07FF, 16'h0080));
                    else
                        cp = 16'($urandom_range(16'hFFFF, 16'h0800));
                    add_hex_escape(cp);
                end
                else if (r == 8)
                begin
                    add_item(CH_BSLASH, 1'b0, 1'b0);
                    add_item(CH_CR, 1'b0, 1'b0);
                    if ($urandom_range(1))
                        add_item(CH_LF, 1'b0, 1'b0);
                end
                else
                    add_item((close == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE, 1'b0, 1'b0);
            end
            r = $urandom_range(99);
            if (r < 70)
                add_item(close, 1'b0, 1'b0);
            else if (r < 76)
                add_item($urandom_range(1) ? CH_LF : CH_CR, 1'b0, 1'b0);
            else if (r < 82)
            begin
                b = CH_U;
                while (b inside {CH_DQUOTE, CH_SLASH, CH_SQUOTE, CH_BSLASH, CH_LF, CH_CR,
                                 CH_B, CH_F, CH_N, CH_R, CH_T, CH_U})
                    b = 8'($urandom_range(255));
                add_item(CH_BSLASH, 1'b0, 1'b0);
                add_item(b, 1'b0, 1'b0);
            end
            else if (r < 88)
            begin
                add_item(CH_BSLASH, 1'b0, 1'b0);
                add_item(CH_U, 1'b0, 1'b0);
                k = $urandom_range(3);
                for (int i = 0; i < k; i++)
                    add_item(hex_char(4'($urandom_range(15))), 1'b0, 1'b0);
                b = DIGIT_0;
                while (b inside {[DIGIT_0:DIGIT_9], [UPPER_A:UPPER_F], [LOWER_A:LOWER_F]})
                    b = 8'($urandom_range(255));
                add_item(b, 1'b0, 1'b0);
            end
            else if (r < 94)
                add_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            // otherwise leave the string open for the next start to drop
            real_items += stim_q.size() - start_size;
            // Noise between strings: stray bytes and ends, sent while idle unless the string was left open.
            if ($urandom_range(9) == 0)
                add_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        end
        send_all();
    endtask

    initial
    begin : main
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: extremes of the byte, every end condition, restart.
        add_item(UPPER_A, 1'b0, 1'b0);          // byte while idle: ignored
        add_item(8'h00, 1'b0, 1'b1);            // end while idle: nothing
        add_item(CH_DQUOTE, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(CH_SQUOTE, 1'b0, 1'b0);        // other quote passes through
        add_hex_escape(16'hFFFF);               // three-byte form, top value
        add_item(CH_BSLASH, 1'b0, 1'b0);        // escaped CR then LF keeps both
        add_item(CH_CR, 1'b0, 1'b0);
        add_item(CH_LF, 1'b0, 1'b0);
        add_item(CH_DQUOTE, 1'b0, 1'b0);        // close
        add_item(CH_SQUOTE, 1'b1, 1'b0);
        add_item(CH_BSLASH, 1'b0, 1'b0);        // unknown escape
        add_item(8'h78, 1'b0, 1'b0);
        add_item(UPPER_A, 1'b1, 1'b0);          // odd opening byte: double quoted
        add_item(CH_BSLASH, 1'b0, 1'b0);        // bad hex digit
        add_item(CH_U, 1'b0, 1'b0);
        add_item(DIGIT_0, 1'b0, 1'b0);
        add_item(8'h67, 1'b0, 1'b0);
        add_item(CH_SQUOTE, 1'b1, 1'b0);        // raw newline
        add_item(CH_LF, 1'b0, 1'b0);
        add_item(CH_DQUOTE, 1'b1, 1'b0);
        add_item(CH_SQUOTE, 1'b1, 1'b0);        // start while active
        add_item(8'hFF, 1'b1, 1'b1);            // end beats start
        send_idle_pct  = 9;
        recv_stall_pct = 65;
        send_all();
        wait_drain();

        run_phase(9, 65, 45);
        wait_drain();
        run_phase(65, 9, 40);
        wait_drain();
        // No idling, but hold the receiver off for a long stretch first.
        hold_req = 1'b1;
        run_phase(0, 0, 40);
        wait_drain();

        $display("run covered %0d items in and %0d results out", sb.items_in, sb.results_out);
        $display("strings closed by quote: %0d, ended by error: %0d",
                 sb.closed_ok, sb.closed_err);
        if (sb.errors == 0)
            $display("json5_string_unescape_test: clean");
        else
            $display("json5_string_unescape_test: errors");
        $finish;
    end

endmodule
